// File: rtl/core/csq_pkg.sv
// ----------------------------------------------------------------------------
// csq_pkg
// Types, codes and pin helpers shared by the clock phase sequencer modules.
// ----------------------------------------------------------------------------
package csq_pkg;

  localparam logic [4:0] BTN_MASK    = 5'b11111;
  localparam int         NUM_PERIODS = 4;
  localparam int         CFG_IDX_W   = 3;
  localparam int         PERIOD_W    = 16;
  localparam logic [2:0] LAST_STEP   = 3'd6;
  localparam logic [2:0] BREAK_STEP  = 3'd3;

  localparam logic [PERIOD_W-1:0] PERIOD_TURBO_RST  = 16'd9;
  localparam logic [PERIOD_W-1:0] PERIOD_FAST_RST   = 16'd9;
  localparam logic [PERIOD_W-1:0] PERIOD_MEDIUM_RST = 16'd90;
  localparam logic [PERIOD_W-1:0] PERIOD_SLOW_RST   = 16'd9000;

  // control pin bit positions
  localparam int P_FW   = 0;
  localparam int P_FO   = 1;
  localparam int P_HOLD = 2;
  localparam int P_INC  = 3;
  localparam int P_SPC  = 4;
  localparam int P_SOUT = 5;

  typedef enum logic [2:0] {
    M_TURBO = 3'd0,
    M_RUN   = 3'd1,
    M_INSTR = 3'd2,
    M_STEP  = 3'd3,
    M_IDLE  = 3'd4
  } mode_t;

  typedef enum logic {
    KIND_POLL = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  typedef struct packed {
    logic       kind;
    logic [4:0] buttons;
    logic       break_n;
  } in_item_t;

  typedef struct packed {
    logic       freeze_word;
    logic       freeze_opcode;
    logic       hold_output;
    logic       increment_pc;
    logic       store_pc;
    logic       store_output;
    logic [2:0] seq_mode;
    logic [2:0] phase;
    logic [1:0] speed_select;
    logic       enabled;
    logic       last;
  } out_item_t;

  // work handed from front to back
  typedef struct packed {
    logic       turbo;
    logic       brk;
    logic [5:0] pins;
    mode_t      mode;
    logic [2:0] phase;
    logic [1:0] speed;
    logic       enabled;
  } job_t;

  // pins of one step of the pattern of a turbo instruction
  function automatic logic [5:0] turbo_pins(input logic [5:0] pins, input logic [2:0] step,
                                            input logic brk);
    logic [5:0] p;
    p = pins;
    case (step)
      3'd0: begin
        p[P_SOUT] = 1'b0;
        p[P_FW]   = 1'b1;
      end
      3'd1: begin
        p[P_FW] = 1'b0;
        p[P_FO] = 1'b1;
      end
      3'd2: begin
        p[P_FO]   = 1'b0;
        p[P_HOLD] = 1'b1;
        p[P_INC]  = 1'b1;
      end
      3'd3: begin
        p[P_HOLD] = 1'b0;
        p[P_SPC]  = 1'b1;
      end
      3'd4: begin
        p[P_INC] = 1'b0;
        p[P_SPC] = 1'b0;
      end
      3'd5: begin
        if (!brk) p[P_SOUT] = 1'b1;
      end
      3'd6: begin
        p[P_SOUT] = 1'b0;
      end
      default: ;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/core/cpu_clock_phase_sequencer.sv
// ----------------------------------------------------------------------------
// cpu_clock_phase_sequencer
// Front-panel clock sequencer: button debounce, mode control and the
// seven-phase control-pin sequence, with whole-instruction turbo ticks.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------
//  input    | push / full        | in_item  (kind, buttons, break_n)
//  result   | pop / empty        | out_item (pins, mode, phase, ...)
//  config   | cfg_we             | cfg_index, cfg_data
//
//  an item is taken by the front end; a new one may follow
//  every cycle while the two-entry job queue has room
//  a poll or plain tick gives one result, via the job queue and output
//  register; a turbo tick gives seven, set by the back end's step
//  sustained rate: one result per cycle while results are popped
//  reset restarts the front end; full and empty follow the two queues
// ----------------------------------------------------------------------------
module cpu_clock_phase_sequencer #(
  parameter int SAMPLE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  csq_pkg::in_item_t             in_item,
  output logic                          empty,
  input  logic                          pop,
  output csq_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [csq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csq_pkg::PERIOD_W-1:0]  cfg_data
);
  import csq_pkg::*;

  job_t front_job;
  job_t queue_job;
  logic accept;
  logic queue_valid;
  logic queue_pop;
  logic out_valid;

  assign accept = push && !full;
  assign empty  = !out_valid;

  csq_front #(
    .SAMPLE_DEPTH(SAMPLE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .job      (front_job)
  );

  csq_job_fifo u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_job  (front_job),
    .full    (full),
    .rd_en   (queue_pop),
    .rd_valid(queue_valid),
    .rd_job  (queue_job)
  );

  csq_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(queue_valid),
    .job_in   (queue_job),
    .job_pop  (queue_pop),
    .out_valid(out_valid),
    .out_item (out_item),
    .out_pop  (pop)
  );

endmodule

// File: rtl/core/csq_front.sv
// ----------------------------------------------------------------------------
// csq_front
// Debounce ring, button edge handling, postscaler and sequencer state; turns
// each accepted item into one job for the back end.
// ----------------------------------------------------------------------------
module csq_front #(
  parameter int SAMPLE_DEPTH = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  csq_pkg::in_item_t         in_item,
  input  logic                      cfg_we,
  input  logic [csq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csq_pkg::PERIOD_W-1:0]  cfg_data,
  output csq_pkg::job_t             job
);
  import csq_pkg::*;

  localparam int IW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;

  logic [4:0]          ring [SAMPLE_DEPTH];
  logic [IW-1:0]       ring_index;
  logic [4:0]          prev_stable;
  logic                enabled_level;
  mode_t               mode;
  logic [2:0]          cycle_phase;
  logic                reset_pending;
  logic [1:0]          speed_index;
  logic [PERIOD_W-1:0] tick_count;
  logic                timer_on;
  logic [5:0]          control_pins;
  logic [PERIOD_W-1:0] period [NUM_PERIODS];

  logic [4:0]          prev_stable_next;
  logic                enabled_level_next;
  mode_t               mode_next;
  logic [2:0]          cycle_phase_next;
  logic                reset_pending_next;
  logic [1:0]          speed_index_next;
  logic [PERIOD_W-1:0] tick_count_next;
  logic                timer_on_next;
  logic [5:0]          control_pins_next;
  logic [IW-1:0]       ring_index_next;

  function automatic logic [5:0] phase_pins(input logic [5:0] pins, input logic [2:0] ph,
                                            input logic brk);
    logic [5:0] p;
    p = pins;
    case (ph)
      3'd6:    p = '0;
      3'd7:    p = pins;
      default: p = turbo_pins(pins, ph, brk);
    endcase
    return p;
  endfunction

  always_comb begin
    logic [4:0] stable;
    logic [4:0] fall;
    logic       brk;
    logic       run;
    logic [5:0] tp;
    stable = BTN_MASK;
    fall   = '0;
    run    = 1'b0;
    tp     = control_pins;
    brk    = !in_item.break_n;
    prev_stable_next   = prev_stable;
    enabled_level_next = enabled_level;
    mode_next          = mode;
    cycle_phase_next   = cycle_phase;
    reset_pending_next = reset_pending;
    speed_index_next   = speed_index;
    tick_count_next    = tick_count;
    timer_on_next      = timer_on;
    control_pins_next  = control_pins;
    ring_index_next    = (ring_index == IW'(SAMPLE_DEPTH - 1)) ? '0 : ring_index + 1'b1;
    job = '0;

    if (in_item.kind == KIND_POLL) begin
      for (int i = 0; i < SAMPLE_DEPTH; i++) begin
        stable = stable & ((IW'(i) == ring_index) ? in_item.buttons : ring[i]);
      end
      if (stable != prev_stable) begin
        fall               = (stable ^ prev_stable) & prev_stable;
        prev_stable_next   = stable;
        enabled_level_next = stable[0];
        if (fall[0]) begin
          reset_pending_next = 1'b1;
          control_pins_next  = '0;
          mode_next          = M_INSTR;
          cycle_phase_next   = '0;
          timer_on_next      = 1'b1;
        end
        if (fall[1]) begin
          if (stable[0]) begin
            if (mode_next == M_RUN) begin
              mode_next = M_INSTR;
            end else if (mode_next == M_TURBO) begin
              mode_next     = M_IDLE;
              timer_on_next = 1'b1;
            end else begin
              mode_next = M_RUN;
            end
          end else begin
            reset_pending_next = 1'b1;
          end
        end
        if (fall[2] && stable[0]) begin
          mode_next     = M_INSTR;
          timer_on_next = 1'b1;
        end
        if (fall[3] && stable[0]) begin
          mode_next     = M_STEP;
          timer_on_next = 1'b1;
        end
        if (fall[4]) begin
          speed_index_next = speed_index + 1'b1;
          if (speed_index_next != 2'd0 && mode_next == M_TURBO) begin
            mode_next     = M_RUN;
            timer_on_next = 1'b1;
          end
        end
      end
    end else if (mode == M_TURBO) begin
      for (int s = 0; s < 7; s++) begin
        tp = turbo_pins(tp, 3'(s), brk);
      end
      control_pins_next = tp;
      if (brk) begin
        mode_next     = M_IDLE;
        timer_on_next = 1'b1;
      end
    end else begin
      if (timer_on && tick_count != '1) tick_count_next = tick_count + 1'b1;
      if (tick_count_next >= period[speed_index]) begin
        tick_count_next = '0;
        if (reset_pending) begin
          reset_pending_next = 1'b0;
          control_pins_next  = 6'(1 << P_SPC);
          cycle_phase_next   = 3'd6;
          mode_next          = M_INSTR;
        end else begin
          unique case (mode)
            M_STEP: begin
              run       = 1'b1;
              mode_next = M_IDLE;
            end
            M_INSTR: run = 1'b1;
            M_RUN: begin
              if (cycle_phase == 3'd0 && speed_index == 2'd0) begin
                timer_on_next = 1'b0;
                mode_next     = M_TURBO;
              end else begin
                run = 1'b1;
              end
            end
            default: ;
          endcase
          if (run) begin
            control_pins_next = phase_pins(control_pins, cycle_phase, brk);
            if (cycle_phase == BREAK_STEP && brk && mode != M_STEP) mode_next = M_INSTR;
            cycle_phase_next = (cycle_phase >= LAST_STEP) ? 3'd0 : cycle_phase + 1'b1;
            if (mode == M_INSTR && cycle_phase_next == 3'd0) mode_next = M_IDLE;
          end
        end
      end
    end

    job.turbo   = (in_item.kind == KIND_TICK) && (mode == M_TURBO);
    job.brk     = brk;
    job.pins    = job.turbo ? control_pins : control_pins_next;
    job.mode    = mode_next;
    job.phase   = cycle_phase_next;
    job.speed   = speed_index_next;
    job.enabled = enabled_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SAMPLE_DEPTH; i++) ring[i] <= BTN_MASK;
      ring_index    <= '0;
      prev_stable   <= BTN_MASK;
      enabled_level <= 1'b0;
      mode          <= M_IDLE;
      cycle_phase   <= '0;
      reset_pending <= 1'b1;
      speed_index   <= '0;
      tick_count    <= '0;
      timer_on      <= 1'b1;
      control_pins  <= '0;
      period[0]     <= PERIOD_TURBO_RST;
      period[1]     <= PERIOD_FAST_RST;
      period[2]     <= PERIOD_MEDIUM_RST;
      period[3]     <= PERIOD_SLOW_RST;
    end else begin
      if (cfg_we && cfg_index < CFG_IDX_W'(NUM_PERIODS)) begin
        period[cfg_index[1:0]] <= cfg_data;
      end
      if (accept) begin
        if (in_item.kind == KIND_POLL) begin
          ring[ring_index] <= in_item.buttons;
          ring_index       <= ring_index_next;
        end
        prev_stable   <= prev_stable_next;
        enabled_level <= enabled_level_next;
        mode          <= mode_next;
        cycle_phase   <= cycle_phase_next;
        reset_pending <= reset_pending_next;
        speed_index   <= speed_index_next;
        tick_count    <= tick_count_next;
        timer_on      <= timer_on_next;
        control_pins  <= control_pins_next;
      end
    end
  end

endmodule

// File: rtl/core/csq_job_fifo.sv
// ----------------------------------------------------------------------------
// csq_job_fifo
// Two-entry queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module csq_job_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  csq_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output logic          rd_valid,
  output csq_pkg::job_t rd_job
);
  import csq_pkg::*;

  job_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_job   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) slot[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/csq_back.sv
// ----------------------------------------------------------------------------
// csq_back
// Expands jobs into items of the output register, one per cycle while popped.
// ----------------------------------------------------------------------------
module csq_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  csq_pkg::job_t      job_in,
  output logic               job_pop,
  output logic               out_valid,
  output csq_pkg::out_item_t out_item,
  input  logic               out_pop
);
  import csq_pkg::*;

  logic       busy;
  logic [2:0] step;
  logic [5:0] pins;
  job_t       job;

  logic       load;
  logic       gen_valid;
  out_item_t  gen;
  logic [5:0] pins_next;
  job_t       src;
  logic [2:0] src_step;

  assign load = !out_valid || out_pop;

  always_comb begin
    src       = busy ? job : job_in;
    src_step  = busy ? step : 3'd0;
    pins_next = turbo_pins(busy ? pins : job_in.pins, src_step, src.brk);
    gen_valid = busy || job_valid;
    gen.phase        = src.phase;
    gen.speed_select = src.speed;
    gen.enabled      = src.enabled;
    if (src.turbo) begin
      {gen.store_output, gen.store_pc, gen.increment_pc,
       gen.hold_output, gen.freeze_opcode, gen.freeze_word} = pins_next;
      gen.seq_mode = (src.brk && src_step >= BREAK_STEP) ? M_IDLE : M_TURBO;
      gen.last     = (src_step == LAST_STEP);
    end else begin
      {gen.store_output, gen.store_pc, gen.increment_pc,
       gen.hold_output, gen.freeze_opcode, gen.freeze_word} = src.pins;
      gen.seq_mode = src.mode;
      gen.last     = 1'b1;
    end
    job_pop = load && !busy && job_valid;
  end

  always_ff @(posedge clk) begin
    if (load && gen_valid) out_item <= gen;
    if (load && gen_valid) pins <= pins_next;
    if (job_pop) job <= job_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
      step      <= '0;
    end else if (load) begin
      out_valid <= gen_valid;
      if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) busy <= 1'b0;
      end else if (job_valid && job_in.turbo) begin
        busy <= 1'b1;
        step <= 3'd1;
      end
    end
  end

endmodule

// File: rtl/core/csq_checker.sv
// ----------------------------------------------------------------------------
// csq_checker
// Port-level checks on the sequencer's result channel.
// ----------------------------------------------------------------------------
module csq_checker (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input csq_pkg::out_item_t out_item
);
  import csq_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("results pending after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("stalled result changed");

  a_turbo_burst: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !out_item.last) |=> !empty)
    else $error("gap inside a turbo burst");

  a_burst_mode: assert property (@(posedge clk) disable iff (rst)
    (!empty && !out_item.last) |->
      (out_item.seq_mode == M_TURBO || out_item.seq_mode == M_IDLE))
    else $error("multi-result item outside turbo");

  a_phase: assert property (@(posedge clk) disable iff (rst)
    !empty |-> out_item.phase != 3'd7)
    else $error("stray phase on result");

endmodule

bind cpu_clock_phase_sequencer csq_checker u_checker (.*);

// File: verif/tb_cpu_clock_phase_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cpu_clock_phase_sequencer
// Drives poll and tick transfers into the sequencer with random idling on
// both sides and checks every panel result against a cycle-free model of
// debounce, mode control, the seven-phase pin sequence and turbo ticks.
// ----------------------------------------------------------------------------
module tb_cpu_clock_phase_sequencer;
  import csq_pkg::*;

  localparam int SAMPLE_DEPTH = 4;
  localparam int RING_W       = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int IDLE_GAP     = 10;

  // raw button bit positions
  localparam int BTN_MODE  = 0;
  localparam int BTN_DEBUG = 1;
  localparam int BTN_INSTR = 2;
  localparam int BTN_STEP  = 3;
  localparam int BTN_SPEED = 4;

  // period register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TURBO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAST   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW   = 3'd3;

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  in_item_t             in_item;
  logic                 empty;
  logic                 pop;
  out_item_t            out_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PERIOD_W-1:0]  cfg_data;

  cpu_clock_phase_sequencer #(.SAMPLE_DEPTH(SAMPLE_DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // panel model state
  logic [PERIOD_W-1:0] period [NUM_PERIODS];
  logic [4:0]          ring_samples [SAMPLE_DEPTH];
  logic [RING_W-1:0]   ring_pos;
  logic [4:0]          stable_prev;
  logic                mode_line;
  mode_t               seq_state;
  logic [2:0]          step_phase;
  logic                reset_armed;
  logic [1:0]          speed_sel;
  logic [PERIOD_W-1:0] tick_cnt;
  logic                timer_run;
  logic [5:0]          pins;

  out_item_t panel_due[$];
  int        errors;
  int        items_sent;
  bit        quiet_mode;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_error(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic out_item_t panel_status(input logic is_last);
    out_item_t r;
    r.freeze_word   = pins[P_FW];
    r.freeze_opcode = pins[P_FO];
    r.hold_output   = pins[P_HOLD];
    r.increment_pc  = pins[P_INC];
    r.store_pc      = pins[P_SPC];
    r.store_output  = pins[P_SOUT];
    r.seq_mode      = seq_state;
    r.phase         = step_phase;
    r.speed_select  = speed_sel;
    r.enabled       = mode_line;
    r.last          = is_last;
    return r;
  endfunction

  task automatic advance_phase(input bit brk);
    case (step_phase)
      3'd0: begin
        pins[P_SOUT] = 1'b0;
        pins[P_FW]   = 1'b1;
      end
      3'd1: begin
        pins[P_FW] = 1'b0;
        pins[P_FO] = 1'b1;
      end
      3'd2: begin
        pins[P_FO]   = 1'b0;
        pins[P_HOLD] = 1'b1;
        pins[P_INC]  = 1'b1;
      end
      3'd3: begin
        if (brk) seq_state = M_INSTR;
        pins[P_HOLD] = 1'b0;
        pins[P_SPC]  = 1'b1;
      end
      3'd4: begin
        pins[P_INC] = 1'b0;
        pins[P_SPC] = 1'b0;
      end
      3'd5: begin
        if (!brk) pins[P_SOUT] = 1'b1;
      end
      3'd6: pins = '0;
      default: ;
    endcase
    step_phase = (step_phase >= LAST_STEP) ? 3'd0 : step_phase + 3'd1;
  endtask

  // works out the panel results of one accepted item
  task automatic update_panel(input in_item_t it);
    logic [4:0] stable;
    logic [4:0] falls;
    bit         brk;
    brk = (it.break_n == 1'b0);
    if (it.kind == KIND_POLL) begin
      ring_samples[ring_pos] = it.buttons;
      ring_pos = (ring_pos == RING_W'(SAMPLE_DEPTH - 1)) ? '0 : ring_pos + 1'b1;
      stable = BTN_MASK;
      foreach (ring_samples[i]) stable &= ring_samples[i];
      if (stable != stable_prev) begin
        falls = (stable ^ stable_prev) & stable_prev;
        stable_prev = stable;
        mode_line = stable[BTN_MODE];
        if (falls[BTN_MODE]) begin
          reset_armed = 1'b1;
          pins        = '0;
          seq_state   = M_INSTR;
          step_phase  = 3'd0;
          timer_run   = 1'b1;
        end
        if (falls[BTN_DEBUG]) begin
          if (mode_line) begin
            if (seq_state == M_RUN) begin
              seq_state = M_INSTR;
            end else if (seq_state == M_TURBO) begin
              seq_state = M_IDLE;
              timer_run = 1'b1;
            end else begin
              seq_state = M_RUN;
            end
          end else begin
            reset_armed = 1'b1;
          end
        end
        if (falls[BTN_INSTR] && mode_line) begin
          seq_state = M_INSTR;
          timer_run = 1'b1;
        end
        if (falls[BTN_STEP] && mode_line) begin
          seq_state = M_STEP;
          timer_run = 1'b1;
        end
        if (falls[BTN_SPEED]) begin
          speed_sel = speed_sel + 2'd1;
          if (speed_sel != 2'd0 && seq_state == M_TURBO) begin
            seq_state = M_RUN;
            timer_run = 1'b1;
          end
        end
      end
      panel_due.push_back(panel_status(1'b1));
    end else if (seq_state == M_TURBO) begin
      // whole instruction, phase left alone
      for (int s = 0; s < 7; s++) begin
        case (s)
          0: begin
            pins[P_SOUT] = 1'b0;
            pins[P_FW]   = 1'b1;
          end
          1: begin
            pins[P_FW] = 1'b0;
            pins[P_FO] = 1'b1;
          end
          2: begin
            pins[P_FO]   = 1'b0;
            pins[P_HOLD] = 1'b1;
            pins[P_INC]  = 1'b1;
          end
          3: begin
            if (brk) begin
              seq_state = M_IDLE;
              timer_run = 1'b1;
            end
            pins[P_HOLD] = 1'b0;
            pins[P_SPC]  = 1'b1;
          end
          4: begin
            pins[P_INC] = 1'b0;
            pins[P_SPC] = 1'b0;
          end
          5: begin
            if (!brk) pins[P_SOUT] = 1'b1;
          end
          default: pins[P_SOUT] = 1'b0;
        endcase
        panel_due.push_back(panel_status(s == 6));
      end
    end else begin
      if (timer_run && tick_cnt != 16'hFFFF) tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= period[speed_sel]) begin
        tick_cnt = '0;
        if (reset_armed) begin
          reset_armed = 1'b0;
          pins        = '0;
          pins[P_SPC] = 1'b1;
          step_phase  = LAST_STEP;
          seq_state   = M_INSTR;
        end else begin
          case (seq_state)
            M_STEP: begin
              advance_phase(brk);
              seq_state = M_IDLE;
            end
            M_INSTR: begin
              advance_phase(brk);
              if (step_phase == 3'd0) seq_state = M_IDLE;
            end
            M_RUN: begin
              if (step_phase == 3'd0 && speed_sel == 2'd0) begin
                timer_run = 1'b0;
                seq_state = M_TURBO;
              end else begin
                advance_phase(brk);
              end
            end
            M_TURBO: seq_state = M_IDLE;
            default: ;
          endcase
        end
      end
      panel_due.push_back(panel_status(1'b1));
    end
  endtask

  // result checking
  always @(posedge clk) begin
    out_item_t want;
    string     bad;
    if (!rst && pop && !empty) begin
      if (panel_due.size() == 0) begin
        report_error($sformatf("result %h with nothing expected", out_item));
      end else begin
        want = panel_due.pop_front();
        bad  = "";
        if (out_item.freeze_word !== want.freeze_word) bad = {bad, " freeze_word"};
        if (out_item.freeze_opcode !== want.freeze_opcode) bad = {bad, " freeze_opcode"};
        if (out_item.hold_output !== want.hold_output) bad = {bad, " hold_output"};
        if (out_item.increment_pc !== want.increment_pc) bad = {bad, " increment_pc"};
        if (out_item.store_pc !== want.store_pc) bad = {bad, " store_pc"};
        if (out_item.store_output !== want.store_output) bad = {bad, " store_output"};
        if (out_item.seq_mode !== want.seq_mode) bad = {bad, " seq_mode"};
        if (out_item.phase !== want.phase) bad = {bad, " phase"};
        if (out_item.speed_select !== want.speed_select) bad = {bad, " speed_select"};
        if (out_item.enabled !== want.enabled) bad = {bad, " enabled"};
        if (out_item.last !== want.last) bad = {bad, " last"};
        if (bad != "")
          report_error($sformatf("result %h, expected %h, wrong:%s", out_item, want, bad));
      end
    end
  end

  // result side stalls
  initial begin
    int stall;
    pop = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = quiet_mode ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        pop = 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop = 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_item(input kind_t k, input logic [4:0] b, input logic bn);
    int gap;
    gap = quiet_mode ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item.kind    = k;
    in_item.buttons = b;
    in_item.break_n = bn;
    push = 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    update_panel(in_item);
    items_sent++;
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic tick(input logic bn);
    send_item(KIND_TICK, 5'($urandom), bn);
  endtask

  task automatic poll(input logic [4:0] b);
    send_item(KIND_POLL, b, 1'($urandom));
  endtask

  task automatic wait_idle();
    while (panel_due.size() != 0) @(negedge clk);
    repeat (IDLE_GAP) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx < NUM_PERIODS) period[idx[1:0]] = data;
  endtask

  task automatic set_periods(input logic [PERIOD_W-1:0] p0, input logic [PERIOD_W-1:0] p1,
                             input logic [PERIOD_W-1:0] p2, input logic [PERIOD_W-1:0] p3);
    wait_idle();
    write_reg(REG_TURBO, p0);
    write_reg(REG_FAST, p1);
    write_reg(REG_MEDIUM, p2);
    write_reg(REG_SLOW, p3);
  endtask

  // pending reset runs on the first step, then the instruction closes
  task automatic test_power_up();
    set_periods(16'd1, 16'd1, 16'd1, 16'd1);
    tick(1'b1);
    tick(1'b1);
  endtask

  // mode line falls then settles high
  task automatic test_enable();
    poll(5'b11110);
    repeat (SAMPLE_DEPTH) poll(BTN_MASK);
  endtask

  task automatic test_single_instruction();
    tick(1'b1);
    tick(1'b1);
    poll(5'b11011);
    repeat (7) tick(1'b0);
  endtask

  // run at speed zero drops into turbo, then a break ends it
  task automatic test_turbo();
    poll(5'b11101);
    tick(1'b1);
    tick(1'b1);
    tick(1'b0);
  endtask

  task automatic test_step_and_speed();
    poll(5'b10111);
    tick(1'b1);
    poll(5'b01111);
    poll(5'b00000);
  endtask

  task automatic test_period_extremes();
    set_periods(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (3) tick(1'b1);
    wait_idle();
    write_reg(CFG_IDX_W'(NUM_PERIODS + $urandom_range(0, 3)), 16'd0);
    repeat (2) tick(1'b1);
    set_periods(16'd0, 16'd0, 16'd0, 16'd0);
    repeat (3) tick(1'b1);
  endtask

  task automatic press_button(input int idx);
    logic [4:0] raw;
    int         high_polls;
    raw = BTN_MASK;
    raw[idx] = 1'b0;
    repeat ($urandom_range(1, 2)) poll(raw);
    // now and then a release too short to settle
    high_polls = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : SAMPLE_DEPTH;
    repeat (high_polls) poll(BTN_MASK);
  endtask

  task automatic test_random();
    int pick;
    int target;
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 0) begin
        set_periods(16'd1, 16'd1, 16'd1, 16'd1);
      end else begin
        set_periods(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                    16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)));
      end
      quiet_mode = (ph == 2);
      target = items_sent + 18;
      while (items_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          pick = $urandom_range(0, 9);
          if (pick < 3)      press_button(BTN_DEBUG);
          else if (pick < 5) press_button(BTN_INSTR);
          else if (pick < 7) press_button(BTN_STEP);
          else if (pick < 9) press_button(BTN_SPEED);
          else               press_button(BTN_MODE);
        end else if (pick < 90) begin
          repeat ($urandom_range(1, 8)) tick(($urandom_range(0, 7) == 0) ? 1'b0 : 1'b1);
        end else begin
          poll(5'($urandom));
        end
      end
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    rst        = 1'b1;
    push       = 1'b0;
    in_item    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    errors     = 0;
    items_sent = 0;
    quiet_mode = 1'b0;

    period[REG_TURBO[1:0]]  = PERIOD_TURBO_RST;
    period[REG_FAST[1:0]]   = PERIOD_FAST_RST;
    period[REG_MEDIUM[1:0]] = PERIOD_MEDIUM_RST;
    period[REG_SLOW[1:0]]   = PERIOD_SLOW_RST;
    foreach (ring_samples[i]) ring_samples[i] = BTN_MASK;
    ring_pos    = '0;
    stable_prev = BTN_MASK;
    mode_line   = 1'b0;
    seq_state   = M_IDLE;
    step_phase  = 3'd0;
    reset_armed = 1'b1;
    speed_sel   = 2'd0;
    tick_cnt    = '0;
    timer_run   = 1'b1;
    pins        = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_power_up();
    test_enable();
    test_single_instruction();
    test_turbo();
    test_step_and_speed();
    test_period_extremes();
    test_random();

    while (panel_due.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: cpu_clock_phase_sequencer.f
rtl/core/csq_pkg.sv
rtl/core/csq_front.sv
rtl/core/csq_job_fifo.sv
rtl/core/csq_back.sv
rtl/core/cpu_clock_phase_sequencer.sv
rtl/core/csq_checker.sv
verif/tb_cpu_clock_phase_sequencer.sv
